### hdl/focus_target_tracker_unit_assert.svh
// Assertion macros for the focus target tracker.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef FOCUS_TARGET_TRACKER_UNIT_ASSERT_SVH
`define FOCUS_TARGET_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define FTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("focus tracker check failed");
// Next-cycle implication, disabled while reset is asserted
`define FTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("focus tracker check failed");
`else
`define FTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/ftt_pkg.sv
// Shared types and constants for the focus target tracker.
// No dependencies; imported by ftt_mul and focus_target_tracker_unit.
`timescale 1ns / 1ps

package ftt_pkg;

    // Default widths of coordinates and region mass
    localparam int COORD_BITS_DEF = 10;
    localparam int MASS_BITS_DEF  = 20;

    // Region id widths: raw input id and signed tracked id with a "none" code
    localparam int RAW_ID_BITS = 16;
    localparam int ID_BITS     = 17;
    localparam logic [ID_BITS-1:0] NO_ID = '1;

    // Reset values of the target point
    localparam int TARGET_X_RST = 320;
    localparam int TARGET_Y_RST = 240;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_ENTRY = 2'd0;
    localparam logic [1:0] ACT_EOF   = 2'd1;
    localparam logic [1:0] ACT_SHIFT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TARGET_X = 1'b0;
    localparam logic CFG_TARGET_Y = 1'b1;

    // Control of the shared multiply unit
    typedef struct packed {
        logic en;        // load a new product
        logic save_lhs;  // move the current product to the compare operand
    } t_mul_ctl;

endpackage

### hdl/focus_target_tracker_unit.sv
// Focus target tracker top level: region scoring sequencer and track state machine.
// Depends on ftt_pkg, ftt_mul and focus_target_tracker_unit_assert.svh.
`timescale 1ns / 1ps

// A region entry is accepted and its coordinate differences formed, then it passes
// five steps through the single shared multiplier (dx squared, dy squared,
// mass times best distance, best mass times distance, compare). End-of-frame,
// shift and unused codes are done on acceptance. The end-of-frame result sits in an
// output register, so entries of the next frame are taken while it waits; a second
// end-of-frame is held off until the first result is taken.

`include "focus_target_tracker_unit_assert.svh"

module focus_target_tracker_unit
    import ftt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MASS_BITS  = MASS_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_action,
    input  logic [RAW_ID_BITS-1:0]       i_roi_id,
    input  logic [COORD_BITS-1:0]        i_roi_x,
    input  logic [COORD_BITS-1:0]        i_roi_y,
    input  logic [MASS_BITS-1:0]         i_roi_mass,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ID_BITS-1:0]    o_target_id,
    output logic                         o_focused
);

    localparam int DIST_BITS = 2 * COORD_BITS + 1;
    localparam int OP_BITS   = (MASS_BITS > DIST_BITS) ? MASS_BITS : DIST_BITS;
    localparam int PROD_BITS = 2 * OP_BITS;

    // Sequencer steps
    localparam logic [2:0] SQ_IDLE = 3'd0;
    localparam logic [2:0] SQ_MX   = 3'd1;
    localparam logic [2:0] SQ_MY   = 3'd2;
    localparam logic [2:0] SQ_MA   = 3'd3;
    localparam logic [2:0] SQ_MB   = 3'd4;
    localparam logic [2:0] SQ_CMP  = 3'd5;

    // Tracking states
    localparam logic [1:0] ST_SEARCH = 2'd0;
    localparam logic [1:0] ST_TRACK  = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    logic [2:0]             r_seq;
    logic [1:0]             r_fsm;
    logic [1:0]             n_fsm;
    logic [ID_BITS-1:0]     r_tracked;
    logic [ID_BITS-1:0]     n_tracked;
    logic [ID_BITS-1:0]     r_best_id;
    logic [MASS_BITS-1:0]   r_best_mass;
    logic [DIST_BITS-1:0]   r_best_dist;
    logic                   r_seen;
    logic                   r_nonempty;
    logic [COORD_BITS-1:0]  r_tx;
    logic [COORD_BITS-1:0]  r_ty;
    logic                   r_out_valid;
    logic [ID_BITS-1:0]     r_out_id;
    logic                   r_out_focused;
    logic [COORD_BITS-1:0]  r_dx;
    logic [COORD_BITS-1:0]  r_dy;
    logic [MASS_BITS-1:0]   r_mass;
    logic [ID_BITS-1:0]     r_id;
    logic [DIST_BITS-1:0]   r_dist;

    logic                   w_in_acc;
    logic                   w_out_acc;
    logic [COORD_BITS-1:0]  w_dx_raw;
    logic [COORD_BITS-1:0]  w_dy_raw;
    logic [COORD_BITS-1:0]  w_dx;
    logic [COORD_BITS-1:0]  w_dy;
    logic [ID_BITS-1:0]     w_in_id;
    t_mul_ctl               w_mul_ctl;
    logic [OP_BITS-1:0]     w_op_a;
    logic [OP_BITS-1:0]     w_op_b;
    logic [PROD_BITS-1:0]   w_prod;
    logic                   w_gt;

    // Handshakes: hold off a second end-of-frame while a result is still pending
    assign o_ready   = (r_seq == SQ_IDLE) &&
                       ((i_action != ACT_EOF) || !r_out_valid || i_ready);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_out_valid && i_ready;

    // Absolute coordinate differences, zero counts as one
    assign w_dx_raw = (i_roi_x > r_tx) ? (i_roi_x - r_tx) : (r_tx - i_roi_x);
    assign w_dy_raw = (i_roi_y > r_ty) ? (i_roi_y - r_ty) : (r_ty - i_roi_y);
    assign w_dx     = (w_dx_raw == '0) ? COORD_BITS'(1) : w_dx_raw;
    assign w_dy     = (w_dy_raw == '0) ? COORD_BITS'(1) : w_dy_raw;
    assign w_in_id  = ID_BITS'(i_roi_id);

    // Step the track machine at end of frame
    always_comb begin
        n_fsm     = r_fsm;
        n_tracked = r_tracked;
        case (r_fsm)
            ST_TRACK: begin
                if (!r_seen) begin
                    n_fsm = ST_LOST;
                end
            end
            ST_LOST: begin
                n_fsm = ST_SEARCH;
            end
            default: begin
                n_fsm = ST_SEARCH;
                if (r_nonempty) begin
                    n_tracked = r_best_id;
                    if (r_best_id != NO_ID) begin
                        n_fsm = ST_TRACK;
                    end
                end
            end
        endcase
    end

    // Select operands for the shared multiplier
    always_comb begin
        case (r_seq)
            SQ_MX: begin
                w_op_a = OP_BITS'(r_dx);
                w_op_b = OP_BITS'(r_dx);
            end
            SQ_MY: begin
                w_op_a = OP_BITS'(r_dy);
                w_op_b = OP_BITS'(r_dy);
            end
            SQ_MA: begin
                w_op_a = OP_BITS'(r_mass);
                w_op_b = OP_BITS'(r_best_dist);
            end
            SQ_MB: begin
                w_op_a = OP_BITS'(r_best_mass);
                w_op_b = OP_BITS'(r_dist);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_mul_ctl.en       = r_seq inside {SQ_MX, SQ_MY, SQ_MA, SQ_MB};
    assign w_mul_ctl.save_lhs = (r_seq == SQ_MB);

    ftt_mul #(
        .OP_BITS (OP_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod),
        .o_gt   (w_gt)
    );

    // Control state, frame accumulation and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_fsm       <= ST_SEARCH;
            r_tracked   <= NO_ID;
            r_best_id   <= NO_ID;
            r_best_mass <= '0;
            r_best_dist <= DIST_BITS'(1);
            r_seen      <= 1'b0;
            r_nonempty  <= 1'b0;
            r_tx        <= COORD_BITS'(TARGET_X_RST);
            r_ty        <= COORD_BITS'(TARGET_Y_RST);
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_X: r_tx <= i_cfg_data;
                    CFG_TARGET_Y: r_ty <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the result once taken, unless a new one replaces it
            if (w_out_acc && !(w_in_acc && (i_action == ACT_EOF))) begin
                r_out_valid <= 1'b0;
            end

            case (r_seq)
                SQ_IDLE: begin
                    if (w_in_acc) begin
                        case (i_action)
                            ACT_ENTRY: begin
                                r_seq      <= SQ_MX;
                                r_nonempty <= 1'b1;
                                if (w_in_id == r_tracked) begin
                                    r_seen <= 1'b1;
                                end
                            end
                            ACT_EOF: begin
                                r_fsm       <= n_fsm;
                                r_tracked   <= n_tracked;
                                r_out_valid <= 1'b1;
                                r_best_id   <= NO_ID;
                                r_best_mass <= '0;
                                r_best_dist <= DIST_BITS'(1);
                                r_seen      <= 1'b0;
                                r_nonempty  <= 1'b0;
                            end
                            ACT_SHIFT: begin
                                r_fsm <= ST_SEARCH;
                            end
                            default: ;
                        endcase
                    end
                end
                SQ_MX:  r_seq <= SQ_MY;
                SQ_MY:  r_seq <= SQ_MA;
                SQ_MA:  r_seq <= SQ_MB;
                SQ_MB:  r_seq <= SQ_CMP;
                SQ_CMP: begin
                    // keep the entry only if strictly more interesting
                    if (w_gt) begin
                        r_best_id   <= r_id;
                        r_best_mass <= r_mass;
                        r_best_dist <= r_dist;
                    end
                    r_seq <= SQ_IDLE;
                end
                default: r_seq <= SQ_IDLE;
            endcase
        end
    end

    // Payload registers: entry operands, squared distance and result
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_action == ACT_ENTRY)) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_mass <= i_roi_mass;
            r_id   <= w_in_id;
        end
        if (w_in_acc && (i_action == ACT_EOF)) begin
            r_out_id      <= n_tracked;
            r_out_focused <= (n_fsm == ST_TRACK);
        end
        // accumulate dx squared plus dy squared
        if (r_seq == SQ_MY) begin
            r_dist <= w_prod[DIST_BITS-1:0];
        end else if (r_seq == SQ_MA) begin
            r_dist <= r_dist + w_prod[DIST_BITS-1:0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_target_id = r_out_id;
    assign o_focused   = r_out_focused;

    // Checks
    `FTT_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n, r_seq != SQ_IDLE, !o_ready)
    `FTT_ASSERT_NEXT(a_eof_gives_result, i_clk, i_rst_n, w_in_acc && (i_action == ACT_EOF), o_valid)
    `FTT_ASSERT_IMPL(a_focused_has_id, i_clk, i_rst_n, o_valid && o_focused, r_out_id != NO_ID)
    `FTT_ASSERT_IMPL(a_entry_len, i_clk, i_rst_n, w_in_acc && (i_action == ACT_ENTRY), ##6 (r_seq == SQ_IDLE))

endmodule

### hdl/ftt_mul.sv
// Shared multiplier with product register and magnitude compare.
// Depends on ftt_pkg for the control struct.
`timescale 1ns / 1ps

module ftt_mul
    import ftt_pkg::*;
#(
    parameter int OP_BITS = 2 * COORD_BITS_DEF + 1
) (
    input  logic                   i_clk,
    input  t_mul_ctl               i_ctl,
    input  logic [OP_BITS-1:0]     i_a,
    input  logic [OP_BITS-1:0]     i_b,
    output logic [2*OP_BITS-1:0]   o_prod,
    output logic                   o_gt
);

    logic [2*OP_BITS-1:0] r_prod;
    logic [2*OP_BITS-1:0] r_lhs;

    // Register the product; park the previous one as the compare operand
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.save_lhs) begin
            r_lhs <= r_prod;
        end
    end

    // Strict compare of the parked product against the current one
    assign o_gt   = (r_lhs > r_prod);
    assign o_prod = r_prod;

endmodule
